// File: hw/rtl/tsrc_pkg.sv
// Shared types and constants for the TCP scan reply classifier.
package tsrc_pkg;

    localparam int unsigned POS_W   = 7;
    localparam int unsigned WORDS_W = 4;

    localparam logic [POS_W-1:0]   ETH_HDR_BYTES = 7'd14;
    localparam logic [POS_W-1:0]   POS_MAX       = 7'd127;
    localparam logic [POS_W-1:0]   POS_STEP      = 7'd1;
    localparam logic [POS_W-1:0]   DOFF_OFFSET   = 7'd12;
    localparam logic [POS_W-1:0]   FLAGS_OFFSET  = 7'd13;
    localparam logic [WORDS_W-1:0] MIN_HDR_WORDS = 4'd5;

    // bit positions in the TCP flags byte
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_RST_BIT = 2;
    localparam int unsigned FLAG_ACK_BIT = 4;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        V_OPEN     = 3'd0,
        V_CLOSED   = 3'd1,
        V_FILTERED = 3'd2,
        V_BAD_IP   = 3'd3,
        V_BAD_TCP  = 3'd4
    } verdict_t;

    typedef struct packed {
        logic       command;
        logic [7:0] frame_byte;
        logic       frame_last;
    } item_t;

    typedef struct packed {
        logic     fire;
        verdict_t verdict;
    } decision_t;

endpackage

// File: hw/rtl/tcp_scan_reply_classifier.sv
// Top level of the TCP scan reply classifier.
// Classifies the reply to a TCP SYN probe from a captured Ethernet frame fed one
// byte per transaction, mixed with receive-timeout ticks (command = 1). Byte 14
// carries the IP header length; the TCP data offset and flags follow that header.
// Verdicts: 0 open (SYN+ACK, also when RST is set), 1 closed (RST+ACK),
// 2 filtered (second timeout with no result in between), 3 bad IP header
// length, 4 bad TCP header length. Frames with other flags or that end early
// give no verdict. A timeout restarts parsing at byte 0. Throughput is one
// transaction per cycle. The input register captures an accepted transaction
// and the parser's verdict is loaded into the result register, which drives
// verdict_valid, when that transaction advances. The input side keeps accepting
// while a verdict waits, and only stalls when a new verdict is produced while the
// result register is still full and not being read in that cycle.
module tcp_scan_reply_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic       command,
    input  logic [7:0] frame_byte,
    input  logic       frame_last,
    output logic       verdict_valid,
    input  logic       verdict_ready,
    output logic [2:0] verdict
);

    tsrc_pkg::item_t     item;
    tsrc_pkg::item_t     stage_item;
    tsrc_pkg::decision_t decision;
    logic                stage_valid;
    logic                advance;

    assign item.command    = command;
    assign item.frame_byte = frame_byte;
    assign item.frame_last = frame_last;

    // stage 1: input register
    tsrc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // parse state commits only when the staged transaction moves on
    tsrc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_item (stage_item),
        .advance    (advance),
        .decision   (decision)
    );

    // stage 2: result register
    tsrc_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .decision      (decision),
        .stage_valid   (stage_valid),
        .advance       (advance),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

endmodule

// File: hw/rtl/tsrc_in_stage.sv
// Input register stage: holds one accepted transaction until the parser takes it.
module tsrc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  tsrc_pkg::item_t item,
    input  logic           advance,
    output logic           stage_valid,
    output tsrc_pkg::item_t stage_item
);

    logic            valid_reg;
    logic            valid_next;
    tsrc_pkg::item_t item_reg;
    logic            accept;

    assign item_ready = !valid_reg || advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// File: hw/rtl/tsrc_parser.sv
// Frame parser: position counter, header length, timeout mark and verdict decision.
module tsrc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  tsrc_pkg::item_t     stage_item,
    input  logic                advance,
    output tsrc_pkg::decision_t decision
);

    logic [tsrc_pkg::POS_W-1:0]   pos_reg;
    logic [tsrc_pkg::POS_W-1:0]   pos_next;
    logic [tsrc_pkg::WORDS_W-1:0] words_reg;
    logic [tsrc_pkg::WORDS_W-1:0] words_next;
    logic                         decided_reg;
    logic                         decided_next;
    logic                         armed_reg;
    logic                         armed_next;

    logic [tsrc_pkg::POS_W-1:0]   tcp_start;
    logic [7:0]                   b;
    logic                         syn_ack;
    logic                         rst_ack;

    assign b         = stage_item.frame_byte;
    assign tcp_start = tsrc_pkg::ETH_HDR_BYTES
                     + {1'b0, words_reg, 2'b00};
    assign syn_ack   = b[tsrc_pkg::FLAG_SYN_BIT] && b[tsrc_pkg::FLAG_ACK_BIT];
    assign rst_ack   = b[tsrc_pkg::FLAG_RST_BIT] && b[tsrc_pkg::FLAG_ACK_BIT];

    always_comb
    begin
        decision.fire    = 1'b0;
        decision.verdict = tsrc_pkg::V_OPEN;
        pos_next         = pos_reg;
        words_next       = words_reg;
        decided_next     = decided_reg;
        armed_next       = armed_reg;

        if (stage_item.command == tsrc_pkg::CMD_TIMEOUT)
        begin
            pos_next     = '0;
            decided_next = 1'b0;
            if (armed_reg)
            begin
                decision.fire    = 1'b1;
                decision.verdict = tsrc_pkg::V_FILTERED;
                armed_next       = 1'b0;
            end
            else
            begin
                armed_next = 1'b1;
            end
        end
        else
        begin
            if (!decided_reg)
            begin
                if (pos_reg == tsrc_pkg::ETH_HDR_BYTES)
                begin
                    words_next = b[3:0];
                    if (b[3:0] < tsrc_pkg::MIN_HDR_WORDS)
                    begin
                        decision.fire    = 1'b1;
                        decision.verdict = tsrc_pkg::V_BAD_IP;
                    end
                end
                else if (pos_reg > tsrc_pkg::ETH_HDR_BYTES)
                begin
                    if (pos_reg == tcp_start + tsrc_pkg::DOFF_OFFSET)
                    begin
                        if (b[7:4] < tsrc_pkg::MIN_HDR_WORDS)
                        begin
                            decision.fire    = 1'b1;
                            decision.verdict = tsrc_pkg::V_BAD_TCP;
                        end
                    end
                    else if (pos_reg == tcp_start + tsrc_pkg::FLAGS_OFFSET)
                    begin
                        // SYN+ACK wins when RST is also set
                        decided_next = 1'b1;
                        if (syn_ack)
                        begin
                            decision.fire    = 1'b1;
                            decision.verdict = tsrc_pkg::V_OPEN;
                        end
                        else if (rst_ack)
                        begin
                            decision.fire    = 1'b1;
                            decision.verdict = tsrc_pkg::V_CLOSED;
                        end
                    end
                end
            end

            if (decision.fire)
            begin
                armed_next   = 1'b0;
                decided_next = 1'b1;
            end

            if (stage_item.frame_last)
            begin
                pos_next     = '0;
                decided_next = 1'b0;
            end
            else if (pos_reg < tsrc_pkg::POS_MAX)
            begin
                pos_next = pos_reg + tsrc_pkg::POS_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            words_reg   <= '0;
            decided_reg <= 1'b0;
            armed_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            words_reg   <= words_next;
            decided_reg <= decided_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

// File: hw/rtl/tsrc_out_stage.sv
// Result register: one verdict waiting for the downstream handshake.
module tsrc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  tsrc_pkg::decision_t decision,
    input  logic                stage_valid,
    output logic                advance,
    output logic                verdict_valid,
    input  logic                verdict_ready,
    output logic [2:0]          verdict
);

    logic               valid_reg;
    logic               valid_next;
    tsrc_pkg::verdict_t verdict_reg;
    logic               load;

    // items without a result pass regardless of the output slot
    assign advance = stage_valid
                  && (!decision.fire || !valid_reg || verdict_ready);
    assign load    = advance && decision.fire;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (verdict_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= decision.verdict;
        end
    end

    assign verdict_valid = valid_reg;
    assign verdict       = verdict_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the TCP scan reply classifier with a verdict predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit, in cycles with no transaction on either channel. The slowest
    // correct stretch is the long receiver hold below; this leaves a wide margin
    // over it.
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_TICKS  = 60;
    localparam int END_QUIET   = 8;
    localparam int PHASE_ITEMS = 40;

    localparam logic [7:0] SYN_MASK = 8'(1 << tsrc_pkg::FLAG_SYN_BIT);
    localparam logic [7:0] RST_MASK = 8'(1 << tsrc_pkg::FLAG_RST_BIT);
    localparam logic [7:0] ACK_MASK = 8'(1 << tsrc_pkg::FLAG_ACK_BIT);

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       item_valid    = 1'b0;
    logic       item_ready;
    logic       command       = tsrc_pkg::CMD_BYTE;
    logic [7:0] frame_byte    = 8'h00;
    logic       frame_last    = 1'b0;
    logic       verdict_valid;
    logic       verdict_ready = 1'b0;
    logic [2:0] verdict;

    tcp_scan_reply_classifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .frame_byte    (frame_byte),
        .frame_last    (frame_last),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

    always #4 clk = ~clk;

    // Transactions waiting to be offered, and verdicts owed by the block, oldest first.
    tsrc_pkg::item_t    pending_transactions[$];
    tsrc_pkg::verdict_t expected_verdicts[$];

    int items_queued   = 0;
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long receiver hold: the stimulus process flips hold_go, the monitor
    // notices the change and runs the count down itself.
    bit hold_go   = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the parser position, the latched IP header
    // length, whether the current frame is already settled, and the
    // pending-timeout mark.
    // ------------------------------------------------------------------
    logic [tsrc_pkg::POS_W-1:0]   frame_pos    = '0;
    logic [tsrc_pkg::WORDS_W-1:0] ihl_words    = '0;
    bit                           frame_done   = 1'b0;
    bit                           timeout_mark = 1'b0;

    // Advances the predictor by one accepted transaction. Returns 1 when the
    // transaction yields a verdict, which is then left in v.
    function automatic bit classify_transaction(input tsrc_pkg::item_t tr,
                                                output tsrc_pkg::verdict_t v);
        bit hit;
        int tcp_start;
        hit = 1'b0;
        v   = tsrc_pkg::V_OPEN;
        // A timeout tick restarts the parser; a second one with no verdict in between reports filtered.
        if (tr.command == tsrc_pkg::CMD_TIMEOUT)
        begin
            frame_pos  = '0;
            frame_done = 1'b0;
            if (timeout_mark)
            begin
                v            = tsrc_pkg::V_FILTERED;
                timeout_mark = 1'b0;
                hit          = 1'b1;
            end
            else
            begin
                timeout_mark = 1'b1;
            end
            return hit;
        end
        if (!frame_done)
        begin
            tcp_start = int'(tsrc_pkg::ETH_HDR_BYTES) + 4 * int'(ihl_words);
            if (frame_pos == tsrc_pkg::ETH_HDR_BYTES)
            begin
                ihl_words = tr.frame_byte[3:0];
                if (ihl_words < tsrc_pkg::MIN_HDR_WORDS)
                begin
                    v   = tsrc_pkg::V_BAD_IP;
                    hit = 1'b1;
                end
            end
            else if (frame_pos > tsrc_pkg::ETH_HDR_BYTES)
            begin
                if (int'(frame_pos) == tcp_start + int'(tsrc_pkg::DOFF_OFFSET))
                begin
                    if (tr.frame_byte[7:4] < tsrc_pkg::MIN_HDR_WORDS)
                    begin
                        v   = tsrc_pkg::V_BAD_TCP;
                        hit = 1'b1;
                    end
                end
                else if (int'(frame_pos) == tcp_start + int'(tsrc_pkg::FLAGS_OFFSET))
                begin
                    // SYN+ACK wins over RST+ACK when all three are set.
                    if (tr.frame_byte[tsrc_pkg::FLAG_SYN_BIT] &&
                        tr.frame_byte[tsrc_pkg::FLAG_ACK_BIT])
                    begin
                        v   = tsrc_pkg::V_OPEN;
                        hit = 1'b1;
                    end
                    else if (tr.frame_byte[tsrc_pkg::FLAG_RST_BIT] &&
                             tr.frame_byte[tsrc_pkg::FLAG_ACK_BIT])
                    begin
                        v   = tsrc_pkg::V_CLOSED;
                        hit = 1'b1;
                    end
                    else
                    begin
                        // no verdict, frame ignored from here on, mark kept
                        frame_done = 1'b1;
                    end
                end
            end
            if (hit)
            begin
                timeout_mark = 1'b0;
                frame_done   = 1'b1;
            end
        end
        // End of frame rearms the parser; otherwise the position advances and saturates at POS_MAX.
        if (tr.frame_last)
        begin
            frame_pos  = '0;
            frame_done = 1'b0;
        end
        else if (frame_pos != tsrc_pkg::POS_MAX)
        begin
            frame_pos = frame_pos + tsrc_pkg::POS_STEP;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: predicts at each accepted input transaction, then offers the
    // next pending one unless this cycle is picked as a sender gap.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        tsrc_pkg::item_t    nxt;
        tsrc_pkg::verdict_t v;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            command    <= tsrc_pkg::CMD_BYTE;
            frame_byte <= 8'h00;
            frame_last <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (classify_transaction('{command: command, frame_byte: frame_byte,
                                           frame_last: frame_last}, v))
                    expected_verdicts.push_back(v);
            end
            // Valid may only drop or change once the current transaction is taken.
            if (!item_valid || item_ready)
            begin
                if (pending_transactions.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_transactions.pop_front();
                    item_valid <= 1'b1;
                    command    <= nxt.command;
                    frame_byte <= nxt.frame_byte;
                    frame_last <= nxt.frame_last;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted verdict against the oldest prediction
    // and drives the receiver's ready, including the long hold.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        tsrc_pkg::verdict_t want;
        if (!rst_n)
        begin
            verdict_ready <= 1'b0;
            hold_left     <= 0;
        end
        else
        begin
            if (verdict_valid && verdict_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch($sformatf("verdict %0d with none predicted", verdict));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict !== want)
                        report_mismatch($sformatf("verdict %0d, predicted %0d (%s)",
                                                  verdict, want, want.name()));
                end
            end
            if (hold_go != hold_seen)
            begin
                hold_seen     <= hold_go;
                hold_left     <= HOLD_CYCLES;
                verdict_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                verdict_ready <= 1'b0;
            end
            else
            begin
                verdict_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: any stretch with no transaction on either side that runs
    // past the limit means the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (verdict_valid && verdict_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                report_mismatch($sformatf("no transaction for %0d cycles", IDLE_LIMIT));
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic cmd, input logic [7:0] b, input logic last);
        pending_transactions.push_back('{command: cmd, frame_byte: b, frame_last: last});
        items_queued++;
    endtask

    // Byte and last are don't-care on a tick, so they carry random values.
    task automatic push_timeout();
        push_item(tsrc_pkg::CMD_TIMEOUT, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // One frame of len bytes with random filler. ihl goes into the low nibble
    // of byte 14, doff into the high nibble of the TCP data-offset byte, flags
    // into the TCP flags byte. A cut position >= 0 replaces that byte with a
    // timeout tick and drops the rest of the frame.
    task automatic push_frame(input int ihl, input int doff, input logic [7:0] flags,
                              input int len, input int cut_at);
        logic [7:0] b;
        int         tcp_start;
        tcp_start = 14 + 4 * ihl;
        for (int i = 0; i < len; i++)
        begin
            if (i == cut_at)
            begin
                push_timeout();
                return;
            end
            b = 8'($urandom_range(255));
            if (i == int'(tsrc_pkg::ETH_HDR_BYTES))
                b[3:0] = 4'(ihl);
            else if (i == tcp_start + int'(tsrc_pkg::DOFF_OFFSET))
                b[7:4] = 4'(doff);
            else if (i == tcp_start + int'(tsrc_pkg::FLAGS_OFFSET))
                b = flags;
            push_item(tsrc_pkg::CMD_BYTE, b, i == len - 1);
        end
    endtask

    // Bytes needed to reach the flags byte.
    function automatic int min_frame_len(input int ihl);
        return int'(tsrc_pkg::ETH_HDR_BYTES) + 4 * ihl + int'(tsrc_pkg::FLAGS_OFFSET) + 1;
    endfunction

    // Mostly well-formed frames with random content; the rest are ticks,
    // broken frames and loose noise bytes.
    task automatic push_random_sequence();
        int         sel;
        int         ihl;
        int         doff;
        int         need;
        int         len;
        logic [7:0] flags;
        sel   = $urandom_range(99);
        ihl   = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
        doff  = $urandom_range(15, 5);
        need  = min_frame_len(ihl);
        len   = need + (($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6));
        flags = 8'($urandom_range(255));
        case ($urandom_range(3))
            0: flags = flags | SYN_MASK | ACK_MASK;
            1: flags = (flags | RST_MASK | ACK_MASK) & ~SYN_MASK;
            2: ;
            default: flags = flags & ~ACK_MASK;
        endcase
        if (sel < 65)
        begin
            push_frame(ihl, doff, flags, len, -1);
        end
        else if (sel < 75)
        begin
            push_timeout();
        end
        else if (sel < 80)
        begin
            push_frame($urandom_range(4), doff, flags, $urandom_range(40, 15), -1);
        end
        else if (sel < 85)
        begin
            push_frame(ihl, $urandom_range(4), flags, len, -1);
        end
        else if (sel < 90)
        begin
            push_frame(ihl, doff, flags, $urandom_range(need - 1, 1), -1);
        end
        else if (sel < 95)
        begin
            push_frame(ihl, doff, flags, len, $urandom_range(need - 1));
        end
        else
        begin
            repeat ($urandom_range(8, 1))
                push_item(tsrc_pkg::CMD_BYTE, 8'($urandom_range(255)),
                          $urandom_range(3) == 0);
        end
    endtask

    // Sender holds off until everything queued is taken and every predicted
    // verdict has come back. Polled on the falling edge, clear of the
    // driver's and monitor's updates.
    task automatic drain_all();
        while (pending_transactions.size() > 0 || item_valid || expected_verdicts.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int start_items;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start_items    = items_queued;
        while (items_queued - start_items < PHASE_ITEMS)
        begin
            push_random_sequence();
            while (pending_transactions.size() > 32)
                @(negedge clk);
        end
        drain_all();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: timeout pairing and clearing of the mark by a result.
        push_timeout();                                               // arms
        push_timeout();                                               // filtered
        push_timeout();                                               // arms
        push_frame(5, 5, SYN_MASK | ACK_MASK, min_frame_len(5), -1);  // open, clears mark
        push_timeout();                                               // arms again
        push_timeout();                                               // filtered
        // Bad IP header length, at both ends of its range.
        push_frame(0, 5, 8'h00, 15, -1);
        push_frame(4, 5, 8'h00, 20, -1);
        // Bad TCP data offset, with the data-offset byte ending the frame.
        push_frame(5, 4, SYN_MASK | ACK_MASK, min_frame_len(5) - 1, -1);
        // Widest IP and TCP headers.
        push_frame(15, 15, RST_MASK | ACK_MASK, min_frame_len(15), -1);  // closed
        // All three of SYN, RST, ACK: open wins.
        push_frame(5, 5, SYN_MASK | RST_MASK | ACK_MASK, min_frame_len(5), -1);
        // Flags matching neither pair: no verdict, mark survives.
        push_timeout();                                               // arms
        push_frame(5, 5, SYN_MASK, min_frame_len(5), -1);
        push_timeout();                                               // filtered
        // Frame ending just before its flags byte.
        push_frame(5, 5, SYN_MASK | ACK_MASK, min_frame_len(5) - 1, -1);
        // Long frame running the position counter into saturation, then a short one.
        push_frame(5, 5, RST_MASK | ACK_MASK, 140, -1);
        push_frame(0, 5, 8'h00, 15, -1);
        // Timeout in the middle of a frame restarts parsing.
        push_frame(5, 5, SYN_MASK | ACK_MASK, min_frame_len(5), 20);
        push_frame(3, 5, 8'h00, 15, -1);
        drain_all();

        // Random, no idling on either side.
        run_phase(0, 0);

        // Receiver holds off for a long stretch while a run of ticks keeps
        // producing filtered verdicts, so the result register fills and the
        // input side has to stall.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = ~hold_go;
        repeat (HOLD_TICKS) push_timeout();
        drain_all();

        run_phase(63, 0);
        run_phase(0, 63);
        run_phase(22, 22);

        // Closing: receiver always ready, short quiet window to catch a stray verdict.
        recv_stall_pct = 0;
        drain_all();
        repeat (END_QUIET) @(negedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d predicted verdicts never came",
                                      expected_verdicts.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: tcp_scan_reply_classifier.f
hw/rtl/tsrc_pkg.sv
hw/rtl/tsrc_in_stage.sv
hw/rtl/tsrc_parser.sv
hw/rtl/tsrc_out_stage.sv
hw/rtl/tcp_scan_reply_classifier.sv
tb/tb_top.sv
